/* rtl/lspg_pkg.sv */
// Shared types, constants and color helpers for the LED strip pattern generator.
package lspg_pkg;

    typedef enum logic [1:0] {
        CMD_READ = 2'd0,
        CMD_TICK = 2'd1,
        CMD_DRAW = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [8:0] idx;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PEND,
        ST_MODE,
        ST_DIV,
        ST_FILL,
        ST_CHASE,
        ST_RAND,
        ST_PUT,
        ST_MOD,
        ST_RD,
        ST_DONE
    } back_state_t;

    localparam logic [2:0] MODE_SOLID       = 3'd0;
    localparam logic [2:0] MODE_SWIPE       = 3'd1;
    localparam logic [2:0] MODE_CYCLE       = 3'd2;
    localparam logic [2:0] MODE_RAINBOW     = 3'd3;
    localparam logic [2:0] MODE_CHASE_RB    = 3'd4;
    localparam logic [2:0] MODE_CHASE       = 3'd5;

    localparam logic [1:0] CFG_MODE         = 2'd0;
    localparam logic [1:0] CFG_BASE_COLOR   = 2'd1;
    localparam logic [1:0] CFG_STRIP_LENGTH = 2'd2;
    localparam logic [1:0] CFG_FRAME_DELAY  = 2'd3;

    localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'h80200003;

    localparam logic [23:0] RESET_BASE_COLOR   = 24'hFF0000;
    localparam logic [9:0]  RESET_STRIP_LENGTH = 10'd300;
    localparam logic [15:0] RESET_FRAME_DELAY  = 16'd120;

    function automatic logic [23:0] wheel(input logic [7:0] pos);
        logic [7:0] q;
        logic [7:0] r;
        logic [7:0] t;
        logic [23:0] c;
        q = 8'd255 - pos;
        if (q < 8'd85)
        begin
            t = 8'(q * 8'd3);
            c = {8'd255 - t, 8'd0, t};
        end
        else if (q < 8'd170)
        begin
            r = q - 8'd85;
            t = 8'(r * 8'd3);
            c = {8'd0, t, 8'd255 - t};
        end
        else
        begin
            r = q - 8'd170;
            t = 8'(r * 8'd3);
            c = {t, 8'd255 - t, 8'd0};
        end
        return c;
    endfunction

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        logic [31:0] n;
        n = {1'b0, s[31:1]};
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // byte modulo 255
    function automatic logic [7:0] chan_mod(input logic [7:0] b);
        return (b == 8'd255) ? 8'd0 : b;
    endfunction

endpackage

/* rtl/led_strip_pattern_generator_core.sv */
// Top level of the LED strip pattern generator: config registers, front end and back end.
//
//  channel  dir  handshake           tdata                 tuser
//  s_*      in   s_tvalid/s_tready   [8:0] pixel_index     action (0 tick, 1 read)
//  m_*      out  m_tvalid/m_tready   [23:0] pixel_color    frame_drawn
//  cfg_*    in   cfg_we              cfg_wdata by cfg_index (mode, color, length, delay)
//
// A read passes the queue, the idle state, the RAM read state and the done state into
// the result register; a tick with no frame goes from the idle state to the done state.
// A frame writes one pixel per cycle, as the frame buffer RAM has one write port;
// rainbow and cycle first wait for the shared divider, swipe and random swipe use it
// after the put, chase writes every third pixel and random swipe first steps the LFSR.
// A frame that follows a chase frame first clears the chase pixels left behind.
// Reset: a clearing pass writes zero to all MAX_PIXELS entries, one a cycle;
// s_tready stays low until it ends. Config writes are taken at any time.
// Stalls: a two-word queue sits between front and back, and the result register
// holds a word while m_tready is low, so input keeps flowing for a while.
module led_strip_pattern_generator_core #(
    parameter int MAX_PIXELS = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [8:0] pixel_index, rest zero
    input  logic        s_tuser,    // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [23:0] pixel_color
    output logic        m_tuser,    // [0] frame_drawn
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    logic [2:0]  mode_reg;
    logic [23:0] base_color_reg;
    logic [9:0]  strip_length_reg;
    logic [15:0] frame_delay_reg;

    logic           q_valid;
    lspg_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic           clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 3'd0;
            base_color_reg   <= lspg_pkg::RESET_BASE_COLOR;
            strip_length_reg <= lspg_pkg::RESET_STRIP_LENGTH;
            frame_delay_reg  <= lspg_pkg::RESET_FRAME_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lspg_pkg::CFG_MODE:         mode_reg         <= cfg_wdata[2:0];
                lspg_pkg::CFG_BASE_COLOR:   base_color_reg   <= cfg_wdata;
                lspg_pkg::CFG_STRIP_LENGTH: strip_length_reg <= cfg_wdata[9:0];
                lspg_pkg::CFG_FRAME_DELAY:  frame_delay_reg  <= cfg_wdata[15:0];
                default:                    mode_reg         <= mode_reg;
            endcase
        end
    end

    // front: tick counting and classification into read / tick / draw
    lspg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .frame_delay (frame_delay_reg),
        .clearing    (clearing),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    // back: frame buffer, drawing sequencer and result register
    lspg_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .base_color   (base_color_reg),
        .strip_length (strip_length_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

/* rtl/lspg_ram.sv */
// Generic single write port, single read port RAM with registered read.
module lspg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lspg_div.sv */
// Restoring divider, one quotient bit per cycle.
module lspg_div #(
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DW:0]     trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/lspg_front.sv */
// Input side: accepts words, runs the tick counter and queues classified commands.
module lspg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic [15:0]          frame_delay,
    input  logic                 clearing,
    output logic                 q_valid,
    output lspg_pkg::cmd_t       q_cmd,
    input  logic                 q_pop
);

    lspg_pkg::cmd_t ent_reg [2];
    lspg_pkg::cmd_t new_cmd;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic [15:0]    tick_reg, tick_next;
    logic [15:0]    tick_inc;
    logic           push;
    logic           pop;

    assign s_tready = (cnt_reg != 2'd2) && !clearing;
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (cnt_reg != 2'd0);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = ent_reg[rd_ptr_reg];

    // saturating tick count, frame fires once it reaches the delay
    assign tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;

    always_comb
    begin
        new_cmd.idx = s_tdata[8:0];
        tick_next   = tick_reg;
        if (s_tuser)
        begin
            new_cmd.kind = lspg_pkg::CMD_READ;
        end
        else if (tick_inc >= frame_delay)
        begin
            new_cmd.kind = lspg_pkg::CMD_DRAW;
            if (push)
            begin
                tick_next = '0;
            end
        end
        else
        begin
            new_cmd.kind = lspg_pkg::CMD_TICK;
            if (push)
            begin
                tick_next = tick_inc;
            end
        end
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
            tick_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            tick_reg   <= tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

/* rtl/lspg_back.sv */
// Back end: frame buffer sequencer that draws frames and serves pixel reads.
module lspg_back #(
    parameter int MAX_PIXELS = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           mode,
    input  logic [23:0]          base_color,
    input  logic [9:0]           strip_length,
    input  logic                 q_valid,
    input  lspg_pkg::cmd_t       q_cmd,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tuser
);

    localparam int AW  = $clog2(MAX_PIXELS);
    localparam int DW0 = $clog2(MAX_PIXELS + 1);
    localparam int DW  = (DW0 > 10) ? DW0 : 10;
    localparam logic [DW-1:0] MAXP = DW'(MAX_PIXELS);

    lspg_pkg::back_state_t state_reg, state_next;

    logic [DW-1:0] i_reg, i_next;
    logic [7:0]    q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [7:0]    dq_reg, dq_next;
    logic [DW-1:0] dr_reg, dr_next;
    logic [AW-1:0] swipe_pos_reg, swipe_pos_next;
    logic [AW-1:0] rand_pos_reg, rand_pos_next;
    logic [7:0]    cyc_off_reg, cyc_off_next;
    logic [7:0]    cr_off_reg, cr_off_next;
    logic [1:0]    cr_phase_reg, cr_phase_next;
    logic [1:0]    ch_phase_reg, ch_phase_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [1:0]    pend_phase_reg, pend_phase_next;
    logic [31:0]   lfsr_reg, lfsr_next;
    logic [4:0]    rcnt_reg, rcnt_next;
    logic [7:0]    red_reg, red_next;
    logic [7:0]    grn_reg, grn_next;
    logic [23:0]   put_color_reg, put_color_next;
    logic          res_drawn_reg, res_drawn_next;
    logic [23:0]   res_color_reg, res_color_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_drawn_reg, out_drawn_next;
    logic [23:0]   out_color_reg, out_color_next;

    logic [DW-1:0] len;
    logic [DW-1:0] sl_ext;
    logic [DW-1:0] j;
    logic [1:0]    phase;
    logic [DW:0]   r_sum;
    logic [AW-1:0] pos;
    logic [DW-1:0] pos_ext;
    logic [DW-1:0] idx_ext;
    logic [31:0]   lfsr_stepped;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [23:0]   ram_rdata;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [DW-1:0] div_rem;

    lspg_ram #(
        .WIDTH (24),
        .DEPTH (MAX_PIXELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lspg_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // active length: zero counts as one, clipped to the buffer size
    assign sl_ext = DW'(strip_length);
    assign len    = (strip_length == 10'd0) ? DW'(1) : ((sl_ext > MAXP) ? MAXP : sl_ext);

    assign phase = (state_reg == lspg_pkg::ST_PEND) ? pend_phase_reg :
                   ((mode == lspg_pkg::MODE_CHASE_RB) ? cr_phase_reg : ch_phase_reg);
    assign j        = i_reg + DW'(phase);
    assign r_sum    = {1'b0, r_reg} + {1'b0, dr_reg};
    assign pos      = (mode == lspg_pkg::MODE_SWIPE) ? swipe_pos_reg : rand_pos_reg;
    assign pos_ext  = DW'(pos);
    assign idx_ext  = DW'(q_cmd.idx);
    assign lfsr_stepped = lspg_pkg::lfsr_step(lfsr_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign clearing = (state_reg == lspg_pkg::ST_CLEAR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lspg_pkg::ST_CLEAR:
            begin
                if (i_reg == MAXP - DW'(1))
                begin
                    state_next = lspg_pkg::ST_IDLE;
                end
            end
            lspg_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.kind)
                        lspg_pkg::CMD_READ:
                            state_next = (idx_ext < len) ? lspg_pkg::ST_RD : lspg_pkg::ST_DONE;
                        lspg_pkg::CMD_TICK:
                            state_next = lspg_pkg::ST_DONE;
                        lspg_pkg::CMD_DRAW:
                            state_next = pend_valid_reg ? lspg_pkg::ST_PEND : lspg_pkg::ST_MODE;
                        default:
                            state_next = lspg_pkg::ST_DONE;
                    endcase
                end
            end
            lspg_pkg::ST_PEND:
            begin
                if (j >= len)
                begin
                    state_next = lspg_pkg::ST_MODE;
                end
            end
            lspg_pkg::ST_MODE:
            begin
                unique case (mode)
                    lspg_pkg::MODE_SOLID:    state_next = lspg_pkg::ST_FILL;
                    lspg_pkg::MODE_SWIPE:    state_next = lspg_pkg::ST_PUT;
                    lspg_pkg::MODE_CYCLE:    state_next = lspg_pkg::ST_DIV;
                    lspg_pkg::MODE_RAINBOW:  state_next = lspg_pkg::ST_DIV;
                    lspg_pkg::MODE_CHASE_RB: state_next = lspg_pkg::ST_CHASE;
                    lspg_pkg::MODE_CHASE:    state_next = lspg_pkg::ST_CHASE;
                    default:                 state_next = lspg_pkg::ST_RAND;
                endcase
            end
            lspg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = lspg_pkg::ST_FILL;
                end
            end
            lspg_pkg::ST_FILL:
            begin
                if (i_reg == len - DW'(1))
                begin
                    state_next = lspg_pkg::ST_DONE;
                end
            end
            lspg_pkg::ST_CHASE:
            begin
                if (j >= len)
                begin
                    state_next = lspg_pkg::ST_DONE;
                end
            end
            lspg_pkg::ST_RAND:
            begin
                if (rcnt_reg == 5'd23)
                begin
                    state_next = lspg_pkg::ST_PUT;
                end
            end
            lspg_pkg::ST_PUT:
                state_next = lspg_pkg::ST_MOD;
            lspg_pkg::ST_MOD:
            begin
                if (div_done)
                begin
                    state_next = lspg_pkg::ST_DONE;
                end
            end
            lspg_pkg::ST_RD:
                state_next = lspg_pkg::ST_DONE;
            lspg_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lspg_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lspg_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        i_next          = i_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        dq_next         = dq_reg;
        dr_next         = dr_reg;
        swipe_pos_next  = swipe_pos_reg;
        rand_pos_next   = rand_pos_reg;
        cyc_off_next    = cyc_off_reg;
        cr_off_next     = cr_off_reg;
        cr_phase_next   = cr_phase_reg;
        ch_phase_next   = ch_phase_reg;
        pend_valid_next = pend_valid_reg;
        pend_phase_next = pend_phase_reg;
        lfsr_next       = lfsr_reg;
        rcnt_next       = rcnt_reg;
        red_next        = red_reg;
        grn_next        = grn_reg;
        put_color_next  = put_color_reg;
        res_drawn_next  = res_drawn_reg;
        res_color_next  = res_color_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_drawn_next  = out_drawn_reg;
        out_color_next  = out_color_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = j[AW-1:0];
        ram_wdata       = 24'd0;
        ram_raddr       = idx_ext[AW-1:0];
        div_start       = 1'b0;
        div_dividend    = DW'(256);

        unique case (state_reg)
            lspg_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[AW-1:0];
                i_next    = i_reg + DW'(1);
            end
            lspg_pkg::ST_IDLE:
            begin
                i_next = '0;
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    res_drawn_next = (q_cmd.kind == lspg_pkg::CMD_DRAW);
                    res_color_next = 24'd0;
                end
            end
            lspg_pkg::ST_PEND:
            begin
                if (j < len)
                begin
                    ram_we = 1'b1;
                    i_next = i_reg + DW'(3);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    i_next          = '0;
                end
            end
            lspg_pkg::ST_MODE:
            begin
                i_next    = '0;
                rcnt_next = '0;
                if (mode == lspg_pkg::MODE_CYCLE || mode == lspg_pkg::MODE_RAINBOW)
                begin
                    div_start = 1'b1;
                end
                if (mode == lspg_pkg::MODE_SWIPE)
                begin
                    put_color_next = base_color;
                end
            end
            lspg_pkg::ST_DIV:
            begin
                dq_next = div_quot[7:0];
                dr_next = div_rem;
                q_next  = '0;
                r_next  = '0;
            end
            lspg_pkg::ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[AW-1:0];
                unique case (mode)
                    lspg_pkg::MODE_CYCLE: ram_wdata = lspg_pkg::wheel(q_reg + cyc_off_reg);
                    lspg_pkg::MODE_RAINBOW: ram_wdata = lspg_pkg::wheel(q_reg);
                    default: ram_wdata = base_color;
                endcase
                // running i*256/len as quotient plus remainder
                if (r_sum >= {1'b0, len})
                begin
                    r_next = DW'(r_sum - {1'b0, len});
                    q_next = q_reg + dq_reg + 8'd1;
                end
                else
                begin
                    r_next = r_sum[DW-1:0];
                    q_next = q_reg + dq_reg;
                end
                i_next = i_reg + DW'(1);
                if (i_reg == len - DW'(1) && mode == lspg_pkg::MODE_CYCLE)
                begin
                    cyc_off_next = cyc_off_reg + 8'd1;
                end
            end
            lspg_pkg::ST_CHASE:
            begin
                ram_wdata = (mode == lspg_pkg::MODE_CHASE_RB) ?
                            lspg_pkg::wheel(i_reg[7:0] + cr_off_reg) : base_color;
                if (j < len)
                begin
                    ram_we = 1'b1;
                    i_next = i_reg + DW'(3);
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_phase_next = phase;
                    if (mode == lspg_pkg::MODE_CHASE_RB)
                    begin
                        cr_phase_next = (cr_phase_reg == 2'd2) ? 2'd0 : cr_phase_reg + 2'd1;
                        cr_off_next   = cr_off_reg + 8'd1;
                    end
                    else
                    begin
                        ch_phase_next = (ch_phase_reg == 2'd2) ? 2'd0 : ch_phase_reg + 2'd1;
                    end
                end
            end
            lspg_pkg::ST_RAND:
            begin
                lfsr_next = lfsr_stepped;
                rcnt_next = rcnt_reg + 5'd1;
                if (rcnt_reg == 5'd7)
                begin
                    red_next = lspg_pkg::chan_mod(lfsr_stepped[7:0]);
                end
                if (rcnt_reg == 5'd15)
                begin
                    grn_next = lspg_pkg::chan_mod(lfsr_stepped[7:0]);
                end
                if (rcnt_reg == 5'd23)
                begin
                    put_color_next = {red_reg, grn_reg, lspg_pkg::chan_mod(lfsr_stepped[7:0])};
                end
            end
            lspg_pkg::ST_PUT:
            begin
                ram_waddr    = pos;
                ram_wdata    = put_color_reg;
                ram_we       = (pos_ext < len);
                div_start    = 1'b1;
                div_dividend = pos_ext + DW'(1);
            end
            lspg_pkg::ST_MOD:
            begin
                if (div_done)
                begin
                    if (mode == lspg_pkg::MODE_SWIPE)
                    begin
                        swipe_pos_next = div_rem[AW-1:0];
                    end
                    else
                    begin
                        rand_pos_next = div_rem[AW-1:0];
                    end
                end
            end
            lspg_pkg::ST_RD:
                res_color_next = ram_rdata;
            lspg_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_drawn_next = res_drawn_reg;
                    out_color_next = res_color_reg;
                end
            end
            default:
            begin
                i_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lspg_pkg::ST_CLEAR;
            i_reg          <= '0;
            swipe_pos_reg  <= '0;
            rand_pos_reg   <= '0;
            cyc_off_reg    <= '0;
            cr_off_reg     <= '0;
            cr_phase_reg   <= '0;
            ch_phase_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_phase_reg <= '0;
            lfsr_reg       <= lspg_pkg::LFSR_SEED;
            rcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            swipe_pos_reg  <= swipe_pos_next;
            rand_pos_reg   <= rand_pos_next;
            cyc_off_reg    <= cyc_off_next;
            cr_off_reg     <= cr_off_next;
            cr_phase_reg   <= cr_phase_next;
            ch_phase_reg   <= ch_phase_next;
            pend_valid_reg <= pend_valid_next;
            pend_phase_reg <= pend_phase_next;
            lfsr_reg       <= lfsr_next;
            rcnt_reg       <= rcnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        r_reg         <= r_next;
        dq_reg        <= dq_next;
        dr_reg        <= dr_next;
        red_reg       <= red_next;
        grn_reg       <= grn_next;
        put_color_reg <= put_color_next;
        res_drawn_reg <= res_drawn_next;
        res_color_reg <= res_color_next;
        out_drawn_reg <= out_drawn_next;
        out_color_reg <= out_color_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_drawn_reg;
    assign m_tdata  = out_color_reg;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the LED strip pattern generator core.
`timescale 1ns / 1ps

module tb;

    localparam int NPIX = 512;
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;
    localparam logic [2:0] MODE_RAND_SWIPE = 3'd6;
    localparam logic [2:0] MODE_SEVEN      = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [8:0] pixel_index, rest zero
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [23:0] pixel_color
    logic        m_tuser;   // [0] frame_drawn
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_wdata;

    led_strip_pattern_generator_core uut (.*);

    typedef struct packed {
        logic        frame;
        logic [23:0] color;
    } word_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  ci;
        logic [23:0] cv;
        logic        act;
        logic [8:0]  idx;
        logic        known;
        logic        ef;
        logic [23:0] ec;
    } row_t;

    // shadow of the block
    logic [2:0]  sh_mode;
    logic [23:0] sh_color;
    logic [9:0]  sh_len;
    logic [15:0] sh_delay;
    logic [23:0] fb [NPIX];
    logic [15:0] ticks;
    logic [8:0]  swipe_pos, rswipe_pos;
    logic [7:0]  cyc_off, crb_off;
    logic [1:0]  crb_ph, ch_ph, clr_ph;
    logic        clr_pend;
    logic [31:0] lfsr;

    word_t expected_words[$];
    row_t  rows[$];
    int    errs;
    bit    calm;
    int    stall_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [23:0] hue(input logic [7:0] p);
        int q;
        q = 255 - p;
        if (q < 85)
            return {8'(255 - 3 * q), 8'd0, 8'(3 * q)};
        else if (q < 170)
            return {8'd0, 8'(3 * (q - 85)), 8'(255 - 3 * (q - 85))};
        else
            return {8'(3 * (q - 170)), 8'(255 - 3 * (q - 170)), 8'd0};
    endfunction

    function automatic logic [7:0] rand_byte();
        for (int k = 0; k < 8; k++)
        begin
            if (lfsr[0])
                lfsr = (lfsr >> 1) ^ 32'h80200003;
            else
                lfsr = lfsr >> 1;
        end
        return 8'(lfsr[7:0] % 255);
    endfunction

    function automatic int eff_len();
        if (sh_len == 0)
            return 1;
        if (sh_len > NPIX)
            return NPIX;
        return sh_len;
    endfunction

    function automatic void paint(input int i, input logic [23:0] c, input int n);
        if (i < n)
            fb[i] = c;
    endfunction

    function automatic void render();
        int n;
        logic [7:0] r, g, b;
        n = eff_len();
        // chase dots from the previous frame go dark first
        if (clr_pend)
        begin
            for (int i = 0; i < n; i += 3)
                paint(i + clr_ph, 24'd0, n);
            clr_pend = 1'b0;
        end
        case (sh_mode)
            lspg_pkg::MODE_SOLID:
                for (int i = 0; i < n; i++)
                    fb[i] = sh_color;
            lspg_pkg::MODE_SWIPE:
            begin
                paint(swipe_pos, sh_color, n);
                swipe_pos = 9'((swipe_pos + 1) % n);
            end
            lspg_pkg::MODE_CYCLE:
            begin
                for (int i = 0; i < n; i++)
                    fb[i] = hue(8'((i * 256) / n + cyc_off));
                cyc_off++;
            end
            lspg_pkg::MODE_RAINBOW:
                for (int i = 0; i < n; i++)
                    fb[i] = hue(8'((i * 256) / n));
            lspg_pkg::MODE_CHASE_RB:
            begin
                for (int i = 0; i < n; i += 3)
                    paint(i + crb_ph, hue(8'(i + crb_off)), n);
                clr_pend = 1'b1;
                clr_ph = crb_ph;
                crb_ph = (crb_ph == 2) ? 2'd0 : crb_ph + 2'd1;
                crb_off++;
            end
            lspg_pkg::MODE_CHASE:
            begin
                for (int i = 0; i < n; i += 3)
                    paint(i + ch_ph, sh_color, n);
                clr_pend = 1'b1;
                clr_ph = ch_ph;
                ch_ph = (ch_ph == 2) ? 2'd0 : ch_ph + 2'd1;
            end
            default:
            begin
                // random swipe, mode seven too
                r = rand_byte();
                g = rand_byte();
                b = rand_byte();
                paint(rswipe_pos, {r, g, b}, n);
                rswipe_pos = 9'((rswipe_pos + 1) % n);
            end
        endcase
    endfunction

    function automatic word_t predict(input logic act, input logic [8:0] idx);
        word_t w;
        w = '0;
        if (act == ACT_READ)
        begin
            if (idx < eff_len())
                w.color = fb[idx];
            return w;
        end
        if (ticks != 16'hFFFF)
            ticks++;
        if (ticks >= sh_delay)
        begin
            ticks = '0;
            render();
            w.frame = 1'b1;
        end
        return w;
    endfunction

    // hold-off: wait for all words, then for a frame's worth of cycles
    task automatic drain();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] ci, input logic [23:0] cv);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= ci;
        cfg_wdata <= cv;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (ci)
            lspg_pkg::CFG_MODE:         sh_mode  = cv[2:0];
            lspg_pkg::CFG_BASE_COLOR:   sh_color = cv;
            lspg_pkg::CFG_STRIP_LENGTH: sh_len   = cv[9:0];
            default:                    sh_delay = cv[15:0];
        endcase
    endtask

    // one word in; the expectation is queued once it is taken
    task automatic send(input logic act, input logic [8:0] idx, input bit known,
                        input word_t kw);
        word_t w;
        if (!calm && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, idx};
        do
            @(posedge clk);
        while (!s_tready);
        w = predict(act, idx);
        expected_words.push_back(known ? kw : w);
    endtask

    task automatic random_word(input int n);
        logic [8:0] idx;
        if ($urandom_range(9) < 6)
            send(ACT_TICK, 9'($urandom), 1'b0, '0);
        else
        begin
            idx = ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(n - 1));
            send(ACT_READ, idx, 1'b0, '0);
        end
    endtask

    // receiver: m_tready drops low in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (calm)
        begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(18, 0);
        end
        else
            m_tready <= 1'b1;
    end

    // check every word out against the oldest expectation
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                errs++;
                if (errs <= 10)
                    $display("unexpected word: frame %0b color %06h", m_tuser, m_tdata);
            end
            else
            begin
                w = expected_words.pop_front();
                if (w.frame !== m_tuser || w.color !== m_tdata)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("mismatch: exp frame %0b color %06h, got frame %0b color %06h",
                                 w.frame, w.color, m_tuser, m_tdata);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic add_cfg(input logic [1:0] ci, input logic [23:0] cv);
        rows.push_back('{1'b1, ci, cv, 1'b0, 9'd0, 1'b0, 1'b0, 24'd0});
    endtask

    task automatic add_word(input logic act, input logic [8:0] idx);
        rows.push_back('{1'b0, 2'd0, 24'd0, act, idx, 1'b0, 1'b0, 24'd0});
    endtask

    task automatic add_known(input logic act, input logic [8:0] idx, input logic ef,
                             input logic [23:0] ec);
        rows.push_back('{1'b0, 2'd0, 24'd0, act, idx, 1'b1, ef, ec});
    endtask

    initial
    begin
        row_t rw;
        int   n;
        errs      = 0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sh_mode   = lspg_pkg::MODE_SOLID;
        sh_color  = 24'hFF0000;
        sh_len    = 10'd300;
        sh_delay  = 16'd120;
        for (int i = 0; i < NPIX; i++)
            fb[i] = '0;
        ticks = '0; swipe_pos = '0; rswipe_pos = '0; cyc_off = '0; crb_off = '0;
        crb_ph = '0; ch_ph = '0; clr_ph = '0; clr_pend = 1'b0;
        lfsr = 32'hACE1ACE1;

        // directed: reset contents, length extremes, past-end reads, every mode
        add_known(ACT_READ, 9'd0, 1'b0, 24'd0);
        add_known(ACT_READ, 9'd511, 1'b0, 24'd0);
        add_known(ACT_TICK, 9'd0, 1'b0, 24'd0);           // 1 of 120 ticks
        add_cfg(lspg_pkg::CFG_FRAME_DELAY, 24'd0);
        add_known(ACT_TICK, 9'd0, 1'b1, 24'd0);           // solid red
        add_known(ACT_READ, 9'd299, 1'b0, 24'hFF0000);
        add_known(ACT_READ, 9'd300, 1'b0, 24'd0);         // past strip end
        add_cfg(lspg_pkg::CFG_BASE_COLOR, 24'hFFFFFF);
        add_cfg(lspg_pkg::CFG_STRIP_LENGTH, 24'd0);       // zero acts as one
        add_word(ACT_TICK, 9'd0);
        add_known(ACT_READ, 9'd0, 1'b0, 24'hFFFFFF);
        add_known(ACT_READ, 9'd1, 1'b0, 24'd0);
        add_cfg(lspg_pkg::CFG_STRIP_LENGTH, 24'h3FF);     // clamps to 512
        add_cfg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_CHASE});
        add_word(ACT_TICK, 9'd0);
        add_word(ACT_READ, 9'd0);
        add_cfg(lspg_pkg::CFG_MODE, {21'd0, MODE_SEVEN});
        add_word(ACT_TICK, 9'd0);                          // chase dots cleared
        add_word(ACT_READ, 9'd0);
        add_cfg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_CHASE_RB});
        add_word(ACT_TICK, 9'd0);
        add_cfg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_CYCLE});
        add_word(ACT_TICK, 9'd0);
        add_word(ACT_READ, 9'd511);
        add_cfg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_RAINBOW});
        add_word(ACT_TICK, 9'd0);
        add_word(ACT_READ, 9'd256);
        add_cfg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_SWIPE});
        add_word(ACT_TICK, 9'd0);
        add_cfg(lspg_pkg::CFG_MODE, {21'd0, MODE_RAND_SWIPE});
        add_word(ACT_TICK, 9'd0);
        add_word(ACT_READ, 9'd1);

        repeat (6) @(posedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.is_cfg)
            begin
                s_tvalid <= 1'b0;
                write_reg(rw.ci, rw.cv);
            end
            else
                send(rw.act, rw.idx, rw.known, '{rw.ef, rw.ec});
        end

        // swipe far along a long strip, then shorten it: stale position
        s_tvalid <= 1'b0;
        write_reg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_SWIPE});
        write_reg(lspg_pkg::CFG_STRIP_LENGTH, 24'd40);
        for (int k = 0; k < 60; k++)
            random_word(40);
        s_tvalid <= 1'b0;
        write_reg(lspg_pkg::CFG_STRIP_LENGTH, 24'd5);
        for (int k = 0; k < 30; k++)
            random_word(5);
        // chase, then a shorter strip: pending clear uses the new length
        s_tvalid <= 1'b0;
        write_reg(lspg_pkg::CFG_STRIP_LENGTH, 24'd11);
        write_reg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_CHASE});
        send(ACT_TICK, 9'd0, 1'b0, '0);
        s_tvalid <= 1'b0;
        write_reg(lspg_pkg::CFG_STRIP_LENGTH, 24'd4);
        write_reg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_SWIPE});
        for (int k = 0; k < 12; k++)
            random_word(11);

        // random phases, mostly short strips and short delays
        for (int ph = 0; ph < 14; ph++)
        begin
            s_tvalid <= 1'b0;
            write_reg(lspg_pkg::CFG_MODE, 24'($urandom_range(7)));
            write_reg(lspg_pkg::CFG_BASE_COLOR, 24'($urandom));
            case ($urandom_range(5))
                0: n = 512;
                1: n = $urandom_range(512, 1);
                default: n = $urandom_range(24, 1);
            endcase
            write_reg(lspg_pkg::CFG_STRIP_LENGTH, 24'(n));
            write_reg(lspg_pkg::CFG_FRAME_DELAY, 24'($urandom_range(3)));
            if (ph == 12)
                calm = 1'b1;
            for (int k = 0; k < 60; k++)
                random_word(n);
        end

        // longest delay: a burst of ticks draws no frame
        s_tvalid <= 1'b0;
        write_reg(lspg_pkg::CFG_STRIP_LENGTH, 24'd3);
        write_reg(lspg_pkg::CFG_MODE, {21'd0, lspg_pkg::MODE_SOLID});
        write_reg(lspg_pkg::CFG_FRAME_DELAY, 24'hFFFF);
        for (int k = 0; k < 40; k++)
            send(ACT_TICK, 9'($urandom), 1'b0, '0);
        send(ACT_READ, 9'd2, 1'b0, '0);
        s_tvalid <= 1'b0;

        drain();
        if (errs == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
